/* sv/fcd_pkg.sv */
// ----------------------------------------------------------------------------
// fcd_pkg: shared types and constants for the framed command decoder
// Holds the configuration reset values, the result kinds and the structs
// that carry configuration and decoded results between modules.
// ----------------------------------------------------------------------------
package fcd_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned STORE_DEPTH = 4;
	localparam int unsigned RESULT_W    = 6 * BYTE_W;

	localparam logic [BYTE_W-1:0] HEADER_RESET     = 8'h01;
	localparam logic [BYTE_W-1:0] FOOTER_RESET     = 8'h02;
	localparam logic [BYTE_W-1:0] COLOR_OP_RESET   = 8'h48;
	localparam logic [BYTE_W-1:0] BRIGHT_OP_RESET  = 8'h49;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_HEADER    = 2'd0,
		REG_FOOTER    = 2'd1,
		REG_COLOR_OP  = 2'd2,
		REG_BRIGHT_OP = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_COLOR      = 2'd0,
		KIND_BRIGHTNESS = 2'd1,
		KIND_OTHER      = 2'd2,
		KIND_BAD_FOOTER = 2'd3
	} result_kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] header_byte;
		logic [BYTE_W-1:0] footer_byte;
		logic [BYTE_W-1:0] color_opcode;
		logic [BYTE_W-1:0] brightness_opcode;
	} cfg_t;

	typedef struct packed {
		result_kind_t      result_kind;
		logic [BYTE_W-1:0] opcode;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] brightness;
		logic [BYTE_W-1:0] frame_length;
	} result_t;

endpackage

/* sv/fcd_parser.sv */
// ----------------------------------------------------------------------------
// fcd_parser: frame parsing state machine and payload store
// Consumes one registered byte per cycle while step is high, tracks the frame
// position and produces a decoded command or bad-footer result at the footer.
// ----------------------------------------------------------------------------
module fcd_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	input  fcd_pkg::cfg_t         cfg,
	output logic                  emit,
	output fcd_pkg::result_t      result
);
	import fcd_pkg::*;

	typedef enum logic [4:0] {
		ST_RESYNC  = 5'b00001,
		ST_HEADER  = 5'b00010,
		ST_LENGTH  = 5'b00100,
		ST_PAYLOAD = 5'b01000,
		ST_FOOTER  = 5'b10000
	} state_t;

	localparam int unsigned IDX_W = $clog2(STORE_DEPTH);

	state_t            state_q, state_d;
	logic [BYTE_W-1:0] length_q, length_d;
	logic [BYTE_W-1:0] index_q, index_d;
	logic [BYTE_W-1:0] store_q [STORE_DEPTH];
	logic [BYTE_W:0]   next_index;
	logic              store_wr;
	result_kind_t      kind;
	result_kind_t      out_kind;

	assign next_index = {1'b0, index_q} + 1'b1;
	assign store_wr   = step && (state_q == ST_PAYLOAD) && (index_q < BYTE_W'(STORE_DEPTH));

	always_comb begin
		if (store_q[0] == cfg.color_opcode) begin
			kind = KIND_COLOR;
		end else if (store_q[0] == cfg.brightness_opcode) begin
			kind = KIND_BRIGHTNESS;
		end else begin
			kind = KIND_OTHER;
		end
	end

	always_comb begin
		state_d  = state_q;
		length_d = length_q;
		index_d  = index_q;
		emit     = 1'b0;
		out_kind = kind;
		case (state_q)
			ST_RESYNC: begin
				if (rx_byte == cfg.footer_byte) begin
					state_d = ST_HEADER;
				end
			end
			ST_LENGTH: begin
				length_d = rx_byte;
				state_d  = ST_PAYLOAD;
			end
			ST_PAYLOAD: begin
				if (next_index >= {1'b0, length_q}) begin
					index_d = '0;
					state_d = ST_FOOTER;
				end else begin
					index_d = next_index[BYTE_W-1:0];
				end
			end
			ST_FOOTER: begin
				emit = step;
				if (rx_byte == cfg.footer_byte) begin
					state_d = ST_HEADER;
				end else begin
					out_kind = KIND_BAD_FOOTER;
					state_d  = ST_RESYNC;
				end
			end
			default: begin
				if (rx_byte == cfg.header_byte) begin
					state_d = ST_LENGTH;
				end else begin
					state_d = ST_RESYNC;
				end
			end
		endcase
	end

	assign result.result_kind  = out_kind;
	assign result.opcode       = store_q[0];
	assign result.red          = store_q[1];
	assign result.green        = store_q[2];
	assign result.blue         = store_q[3];
	assign result.brightness   = (out_kind == KIND_BRIGHTNESS) ? store_q[1] : '0;
	assign result.frame_length = length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_HEADER;
			length_q <= '0;
			index_q  <= '0;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				store_q[i] <= '0;
			end
		end else if (step) begin
			state_q  <= state_d;
			length_q <= length_d;
			index_q  <= index_d;
			if (store_wr) begin
				store_q[index_q[IDX_W-1:0]] <= rx_byte;
			end
		end
	end

endmodule

/* sv/fcd_out_buf.sv */
// ----------------------------------------------------------------------------
// fcd_out_buf: result register with skid stage
// Holds decoded results for the master side; a second entry absorbs one
// result when the receiver stalls; the parser waits only once both are full.
// ----------------------------------------------------------------------------
module fcd_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fcd_pkg::result_t push_data,
	output logic             can_push,
	output logic             out_valid,
	input  logic             out_ready,
	output fcd_pkg::result_t out_data
);
	import fcd_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;

	assign can_push  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || out_ready) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end else if (out_ready && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register is empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("result pushed while skid entry is occupied");

	a_stall_keeps_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("stalled result dropped");

endmodule

/* sv/framed_command_decoder.sv */
// ----------------------------------------------------------------------------
// framed_command_decoder: length-prefixed serial frame parser
// Decodes header, length, payload and footer bytes into commands.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on the s_ channel, one byte per beat. A frame
// is a header byte, a length byte, the payload bytes and a footer byte. The
// beat that carries a footer position yields one result beat on the m_
// channel: a color, brightness or other-opcode command, or a bad-footer
// error. Every other byte yields no result.
// Each byte is first captured in an input register and parsed once the
// parser steps; a result then passes the output register to m_tvalid.
// The block takes one byte every cycle while parsing is not paused; the output
// register and a skid entry let it keep accepting while one result waits. Once
// both hold results, parsing pauses and s_tready drops while a byte waits in
// the input register; it returns right after the receiver takes a result.
// The cfg_ channel writes the four match registers and is always ready.
// Reset returns the parser to waiting for a header, clears the payload store
// and the frame length, and loads the default match bytes.
// ----------------------------------------------------------------------------
module framed_command_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // rx_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// opcode, red, green, blue, brightness, frame_length
	output logic [fcd_pkg::RESULT_W-1:0] m_tdata,
	output logic [1:0]                   m_tuser,   // result_kind
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [fcd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                   cfg_data
);
	import fcd_pkg::*;

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              step;
	logic              emit;
	logic              can_push;
	result_t           parsed;
	result_t           out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte       <= HEADER_RESET;
			cfg_q.footer_byte       <= FOOTER_RESET;
			cfg_q.color_opcode      <= COLOR_OP_RESET;
			cfg_q.brightness_opcode <= BRIGHT_OP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_HEADER:    cfg_q.header_byte       <= cfg_data;
				REG_FOOTER:    cfg_q.footer_byte       <= cfg_data;
				REG_COLOR_OP:  cfg_q.color_opcode      <= cfg_data;
				REG_BRIGHT_OP: cfg_q.brightness_opcode <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign step     = valid_s1 && can_push;
	assign s_tready = !valid_s1 || can_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	fcd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.emit    (emit),
		.result  (parsed)
	);

	fcd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (parsed),
		.can_push  (can_push),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tuser = out_res.result_kind;
	assign m_tdata = {out_res.frame_length, out_res.brightness, out_res.blue,
		out_res.green, out_res.red, out_res.opcode};

endmodule

/* test/framed_command_decoder_checker.sv */
// ----------------------------------------------------------------------------
// framed_command_decoder_checker: scoreboard for the framed command decoder
// Watches the byte, result and register channels. Every accepted byte runs
// through a local frame parser that holds its own copy of the match bytes.
// A byte that closes a frame queues the decoded command it should produce.
// Each result beat is checked field by field against the oldest queued
// command. The mismatch count and the number of commands still owed are
// handed to the testbench top.
// ----------------------------------------------------------------------------
module framed_command_decoder_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // rx_byte
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// opcode, red, green, blue, brightness, frame_length
	input  logic [fcd_pkg::RESULT_W-1:0]    m_tdata,
	input  logic [1:0]                      m_tuser,   // result_kind
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [fcd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data,
	output int                              mismatch_count,
	output int                              commands_owed
);
	import fcd_pkg::*;

	typedef enum logic [2:0] {
		PH_RESYNC  = 3'd0,
		PH_HEADER  = 3'd1,
		PH_LENGTH  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_FOOTER  = 3'd4
	} parse_phase_t;

	cfg_t         match_bytes;
	parse_phase_t phase;
	logic [7:0]   frame_len;
	logic [7:0]   byte_idx;
	logic [7:0]   payload [STORE_DEPTH];
	result_t      owed_commands [$];

	function automatic result_t decoded_command(result_kind_t kind);
		result_t r;
		r.result_kind  = kind;
		r.opcode       = payload[0];
		r.red          = payload[1];
		r.green        = payload[2];
		r.blue         = payload[3];
		r.brightness   = (kind == KIND_BRIGHTNESS) ? payload[1] : 8'h00;
		r.frame_length = frame_len;
		return r;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%02h, got 0x%02h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t      got;
		result_t      want;
		result_kind_t kind;
		if (!arst_n) begin
			match_bytes = '{HEADER_RESET, FOOTER_RESET, COLOR_OP_RESET, BRIGHT_OP_RESET};
			phase       = PH_HEADER;
			frame_len   = '0;
			byte_idx    = '0;
			foreach (payload[i])
				payload[i] = '0;
			owed_commands.delete();
			mismatch_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg_index))
					REG_HEADER:    match_bytes.header_byte       = cfg_data;
					REG_FOOTER:    match_bytes.footer_byte       = cfg_data;
					REG_COLOR_OP:  match_bytes.color_opcode      = cfg_data;
					REG_BRIGHT_OP: match_bytes.brightness_opcode = cfg_data;
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				case (phase)
					PH_RESYNC: begin
						if (s_tdata == match_bytes.footer_byte)
							phase = PH_HEADER;
					end
					PH_LENGTH: begin
						frame_len = s_tdata;
						phase     = PH_PAYLOAD;
					end
					PH_PAYLOAD: begin
						if (byte_idx < STORE_DEPTH)
							payload[byte_idx[1:0]] = s_tdata;
						// A zero length still ends after one payload byte.
						if ({1'b0, byte_idx} + 9'd1 >= {1'b0, frame_len}) begin
							byte_idx = '0;
							phase    = PH_FOOTER;
						end else begin
							byte_idx = byte_idx + 8'd1;
						end
					end
					PH_FOOTER: begin
						if (s_tdata == match_bytes.footer_byte) begin
							if (payload[0] == match_bytes.color_opcode)
								kind = KIND_COLOR;
							else if (payload[0] == match_bytes.brightness_opcode)
								kind = KIND_BRIGHTNESS;
							else
								kind = KIND_OTHER;
							owed_commands.push_back(decoded_command(kind));
							phase = PH_HEADER;
						end else begin
							owed_commands.push_back(decoded_command(KIND_BAD_FOOTER));
							phase = PH_RESYNC;
						end
					end
					default: begin
						if (s_tdata == match_bytes.header_byte)
							phase = PH_LENGTH;
						else
							phase = PH_RESYNC;
					end
				endcase
			end

			if (m_tvalid && m_tready) begin
				got.result_kind  = result_kind_t'(m_tuser);
				got.opcode       = m_tdata[7:0];
				got.red          = m_tdata[15:8];
				got.green        = m_tdata[23:16];
				got.blue         = m_tdata[31:24];
				got.brightness   = m_tdata[39:32];
				got.frame_length = m_tdata[47:40];
				if (owed_commands.size() == 0) begin
					$error("result beat with no command owed: kind %0d opcode 0x%02h",
						m_tuser, got.opcode);
					mismatch_count++;
				end else begin
					want = owed_commands.pop_front();
					check_field("result_kind", 8'(want.result_kind), 8'(got.result_kind));
					check_field("opcode", want.opcode, got.opcode);
					check_field("red", want.red, got.red);
					check_field("green", want.green, got.green);
					check_field("blue", want.blue, got.blue);
					check_field("brightness", want.brightness, got.brightness);
					check_field("frame_length", want.frame_length, got.frame_length);
				end
			end
		end
		commands_owed = owed_commands.size();
	end

endmodule

/* test/framed_command_decoder_tb.sv */
// ----------------------------------------------------------------------------
// framed_command_decoder_tb: stimulus and verdict for the framed command decoder
// Feeds a short set of hand-built frames covering every command kind, the
// zero and long lengths, a bad footer, resync and a missing header, then
// random frames, noise and broken frames under three sets of match bytes.
// Sender and receiver stall at random; the checker predicts and compares.
// ----------------------------------------------------------------------------
module framed_command_decoder_tb;
	import fcd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata   = '0;   // rx_byte
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	// opcode, red, green, blue, brightness, frame_length
	logic [RESULT_W-1:0]    m_tdata;
	logic [1:0]             m_tuser;          // result_kind
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [7:0]             cfg_data  = '0;

	int mismatch_count;
	int commands_owed;
	int cycle_count   = 0;
	int bytes_sent    = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	logic [7:0] header_val = HEADER_RESET;
	logic [7:0] footer_val = FOOTER_RESET;
	logic [7:0] color_val  = COLOR_OP_RESET;
	logic [7:0] bright_val = BRIGHT_OP_RESET;

	framed_command_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	framed_command_decoder_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.commands_owed  (commands_owed)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// Holds off the sender until every owed command has come back, then lets
	// the input register and parser empty before anything else happens.
	task automatic wait_for_commands();
		s_tvalid <= 1'b0;
		repeat (4) @(posedge clk);
		while (commands_owed != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_match_bytes(logic [7:0] hdr, logic [7:0] ftr,
			logic [7:0] col, logic [7:0] bri);
		logic [7:0] values [4];
		values = '{hdr, ftr, col, bri};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_INDEX_W'(i);
			cfg_data  <= values[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid  <= 1'b0;
		header_val = hdr;
		footer_val = ftr;
		color_val  = col;
		bright_val = bri;
	endtask

	task automatic send_frame(logic [7:0] len, logic [7:0] op, logic [7:0] tail);
		int count;
		count = (len == 0) ? 1 : len;
		send_byte(header_val);
		send_byte(len);
		for (int i = 0; i < count; i++)
			send_byte((i == 0) ? op : 8'($urandom_range(255)));
		send_byte(tail);
	endtask

	task automatic send_random_frame();
		int         pick;
		int         len;
		logic [7:0] op;
		logic [7:0] tail;
		pick = $urandom_range(99);
		if (pick < 78) begin
			len = ($urandom_range(99) < 2) ? $urandom_range(7, 40) : $urandom_range(0, 6);
			case ($urandom_range(2))
				0:       op = color_val;
				1:       op = bright_val;
				default: op = 8'($urandom_range(255));
			endcase
			tail = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : footer_val;
			send_frame(8'(len), op, tail);
		end else if (pick < 90) begin
			repeat ($urandom_range(1, 4))
				send_byte(8'($urandom_range(255)));
			send_byte(footer_val);
		end else begin
			len = $urandom_range(1, 6);
			send_byte(header_val);
			send_byte(8'(len));
			repeat ($urandom_range(0, len))
				send_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic run_random_phase(int send_pct, int recv_pct, int item_budget);
		int target;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target        = bytes_sent + item_budget;
		while (bytes_sent < target)
			send_random_frame();
		wait_for_commands();
	endtask

	initial begin
		logic [7:0] directed_bytes [$];
		logic [7:0] same_op;
		send_idle_pct = 36;
		recv_idle_pct = 45;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Color with extreme bytes, brightness keeping older store entries,
		// zero length, bad footer followed by resync, and a missing header.
		directed_bytes = {
			8'h01, 8'h04, 8'h48, 8'hFF, 8'h00, 8'h80, 8'h02,
			8'h01, 8'h02, 8'h49, 8'h7F, 8'h02,
			8'h01, 8'h00, 8'h55, 8'h02,
			8'h01, 8'h01, 8'hAA, 8'h33, 8'h44, 8'h02,
			8'hFE, 8'h02
		};
		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);
		wait_for_commands();

		load_match_bytes(8'h00, 8'hFF, 8'hFF, 8'h00);
		send_frame(8'd6, color_val, footer_val);
		run_random_phase(36, 45, 60);

		// Color and brightness opcodes equal: matching frames decode as color.
		same_op = 8'($urandom_range(255));
		load_match_bytes(8'hFF, 8'h00, same_op, same_op);
		run_random_phase(45, 36, 60);

		load_match_bytes(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_frame(8'd255, color_val, footer_val);
		run_random_phase(0, 0, 40);

		if (mismatch_count == 0 && commands_owed == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* sim.f */
sv/fcd_pkg.sv
sv/fcd_parser.sv
sv/fcd_out_buf.sv
sv/framed_command_decoder.sv
test/framed_command_decoder_checker.sv
test/framed_command_decoder_tb.sv
